[rtl/core/lcd_pkg.sv]
// ----------------------------------------------------------------------------
// lcd_pkg
// Shared types and constants of the multichannel level-crossing detector.
// ----------------------------------------------------------------------------
package lcd_pkg;

    localparam int CHANNELS      = 64;
    localparam int SAMPLE_BITS   = 16;
    localparam int CH_AW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHAN_BITS     = 6;
    localparam int TIME_BITS     = 48;
    localparam int SERIAL_BITS   = 32;
    localparam int EVENT_BITS    = 8;
    localparam int THRESH_BITS   = 16;
    localparam int COUNT_BITS    = 16;

    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD    = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RISING       = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_LENGTH = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EVENT_ID     = 4'd3;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [CHAN_BITS-1:0]          channel;
        logic                          last_in_frame;
        logic [TIME_BITS-1:0]          frame_time;
        logic [TIME_BITS-1:0]          source_time;
        logic [SERIAL_BITS-1:0]        serial;
    } t_in_item;

    typedef struct packed {
        logic [EVENT_BITS-1:0]  event_code;
        logic [TIME_BITS-1:0]   hardware_time;
        logic [TIME_BITS-1:0]   source_stamp;
        logic [SERIAL_BITS-1:0] serial_out;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [CH_AW-1:0]              addr;
        logic                          in_range;
        logic                          last;
        logic [TIME_BITS-1:0]          frame_time;
        logic [TIME_BITS-1:0]          source_time;
        logic [SERIAL_BITS-1:0]        serial;
    } t_op;

    typedef struct packed {
        logic                     we;
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] wdata;
    } t_cfg_wr;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_SKIP,
        MODE_STORE
    } t_mode;

endpackage

[rtl/core/multichannel_level_crossing_detector_top.sv]
// ----------------------------------------------------------------------------
// multichannel_level_crossing_detector_top
// Per-channel threshold crossing detector with a frame-based refractory block.
// ----------------------------------------------------------------------------
// An event appears on o_out_valid once its frame's last sample has passed the
//   input register, queue, execute stage and output register.
// Throughput: one channel sample per cycle unless the event output stalls, set
//   by the single read and single write per cycle on the per-channel history RAM.
// Reset: synchronous, active low; clears channel valid bits, frame state and
//   queue, loads register defaults. No clearing pass, ready the next cycle.
module multichannel_level_crossing_detector_top
    import lcd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_item                 i_in_item,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_item                o_out_item,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata
);

    logic    push, pop, q_full, q_empty;
    t_op     front_op, q_head;
    t_cfg_wr cfg;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.wdata = i_cfg_wdata;

    lcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_push     (push),
        .o_op       (front_op),
        .i_q_full   (q_full)
    );

    lcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    lcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_empty   (q_empty),
        .i_head      (q_head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

[rtl/core/lcd_ram.sv]
// ----------------------------------------------------------------------------
// lcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/lcd_front.sv]
// ----------------------------------------------------------------------------
// lcd_front
// Input register: accepts channel samples and classifies the channel index.
// ----------------------------------------------------------------------------
module lcd_front
    import lcd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    output logic     o_push,
    output t_op      o_op,
    input  logic     i_q_full
);

    logic r_valid, n_valid;
    t_op  r_op, n_op;
    logic [CH_AW+CHAN_BITS-1:0] ch_wide;

    assign o_push     = r_valid && !i_q_full;
    assign o_in_ready = !r_valid || !i_q_full;

    always_comb begin
        ch_wide = {{CH_AW{1'b0}}, i_in_item.channel};
        n_valid = r_valid;
        n_op    = r_op;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (i_in_valid && o_in_ready) begin
            n_valid          = 1'b1;
            n_op.sample      = i_in_item.sample;
            n_op.addr        = ch_wide[CH_AW-1:0];
            n_op.in_range    = ch_wide < (CH_AW+CHAN_BITS)'(CHANNELS);
            n_op.last        = i_in_item.last_in_frame;
            n_op.frame_time  = i_in_item.frame_time;
            n_op.source_time = i_in_item.source_time;
            n_op.serial      = i_in_item.serial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_op <= n_op;
    end

    assign o_op = r_op;

endmodule

[rtl/core/lcd_queue.sv]
// ----------------------------------------------------------------------------
// lcd_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module lcd_queue
    import lcd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_op  o_head
);

    t_op            r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QAW:0]   r_count, n_count;

    assign o_full  = r_count == (QAW+1)'(QDEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

[rtl/core/lcd_back.sv]
// ----------------------------------------------------------------------------
// lcd_back
// Crossing check, frame and refractory state, per-channel history, event out.
// ----------------------------------------------------------------------------
module lcd_back
    import lcd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg_wr   i_cfg,
    input  logic      i_q_empty,
    input  t_op       i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // configuration
    logic signed [THRESH_BITS-1:0] r_threshold, n_threshold;
    logic                          r_rising, n_rising;
    logic [COUNT_BITS-1:0]         r_block_length, n_block_length;
    logic [EVENT_BITS-1:0]         r_event_id, n_event_id;

    // frame state
    logic [COUNT_BITS-1:0] r_block_count, n_block_count;
    t_mode                 r_frame_mode, n_frame_mode;
    logic                  r_frame_start, n_frame_start;
    logic                  r_frame_hit, n_frame_hit;
    logic [CHANNELS-1:0]   r_chan_valid, n_chan_valid;

    // execute stage
    logic r_b_valid, n_b_valid;
    t_op  r_b, n_b;
    logic                          r_fwd_hit, n_fwd_hit;
    logic signed [SAMPLE_BITS-1:0] r_fwd_sample, n_fwd_sample;

    // output register
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic signed [SAMPLE_BITS-1:0] prev;
    t_mode                         cur_mode;
    logic [COUNT_BITS-1:0]         cur_count;
    logic                          cur_hit;
    logic                          b_store, cmp_en, cross_now, hit_now, emit, b_go;

    always_comb begin
        cur_mode  = r_frame_mode;
        cur_count = r_block_count;
        cur_hit   = r_frame_hit;
        if (r_frame_start) begin
            cur_hit = 1'b0;
            if (r_block_count != '0) begin
                cur_count = r_block_count - 1'b1;
                cur_mode  = (cur_count == '0) ? MODE_STORE : MODE_SKIP;
            end else begin
                cur_mode = MODE_NORMAL;
            end
        end
        // last write went to the RAM in the same cycle this item was read
        prev      = r_fwd_hit ? r_fwd_sample : $signed(ram_rdata);
        b_store   = r_b_valid && r_b.in_range && (cur_mode != MODE_SKIP);
        cmp_en    = (cur_mode == MODE_NORMAL) && r_b.in_range && r_chan_valid[r_b.addr];
        cross_now = r_rising ? (prev <= r_threshold && r_b.sample > r_threshold)
                             : (prev >= r_threshold && r_b.sample < r_threshold);
        hit_now   = cur_hit || (cmp_en && cross_now);
        emit      = r_b_valid && r_b.last && (cur_mode == MODE_NORMAL) && hit_now;
        b_go      = r_b_valid && (!emit || !r_out_valid || i_out_ready);
        o_pop     = !i_q_empty && (!r_b_valid || b_go);
    end

    always_comb begin
        n_threshold    = r_threshold;
        n_rising       = r_rising;
        n_block_length = r_block_length;
        n_event_id     = r_event_id;
        n_block_count  = r_block_count;
        n_frame_mode   = r_frame_mode;
        n_frame_start  = r_frame_start;
        n_frame_hit    = r_frame_hit;
        n_chan_valid   = r_chan_valid;
        n_b_valid      = r_b_valid;
        n_b            = r_b;
        n_fwd_hit      = r_fwd_hit;
        n_fwd_sample   = r_fwd_sample;
        n_out_valid    = r_out_valid;
        n_out          = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (b_go) begin
            if (b_store) begin
                n_chan_valid[r_b.addr] = 1'b1;
            end
            if (r_b.last) begin
                n_frame_start = 1'b1;
                n_frame_hit   = 1'b0;
                n_frame_mode  = cur_mode;
                n_block_count = emit ? r_block_length : cur_count;
            end else begin
                n_frame_start = 1'b0;
                n_frame_hit   = hit_now;
                n_frame_mode  = cur_mode;
                n_block_count = cur_count;
            end
            if (emit) begin
                n_out_valid         = 1'b1;
                n_out.event_code    = r_event_id;
                n_out.hardware_time = r_b.frame_time;
                n_out.source_stamp  = r_b.source_time;
                n_out.serial_out    = r_b.serial;
            end
            n_b_valid = 1'b0;
        end

        if (o_pop) begin
            n_b_valid    = 1'b1;
            n_b          = i_head;
            n_fwd_hit    = b_go && b_store && (i_head.addr == r_b.addr);
            n_fwd_sample = r_b.sample;
        end

        if (i_cfg.we) begin
            unique case (i_cfg.index)
                CFG_THRESHOLD:    n_threshold = $signed(i_cfg.wdata[THRESH_BITS-1:0]);
                CFG_RISING:       n_rising    = i_cfg.wdata[0];
                CFG_BLOCK_LENGTH: begin
                    n_block_length = i_cfg.wdata[COUNT_BITS-1:0];
                    if (n_block_count > i_cfg.wdata[COUNT_BITS-1:0]) begin
                        n_block_count = i_cfg.wdata[COUNT_BITS-1:0];
                    end
                end
                CFG_EVENT_ID:     n_event_id  = i_cfg.wdata[EVENT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= '0;
            r_rising       <= 1'b1;
            r_block_length <= '0;
            r_event_id     <= '0;
            r_block_count  <= '0;
            r_frame_mode   <= MODE_NORMAL;
            r_frame_start  <= 1'b1;
            r_frame_hit    <= 1'b0;
            r_chan_valid   <= '0;
            r_b_valid      <= 1'b0;
            r_fwd_hit      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_threshold    <= n_threshold;
            r_rising       <= n_rising;
            r_block_length <= n_block_length;
            r_event_id     <= n_event_id;
            r_block_count  <= n_block_count;
            r_frame_mode   <= n_frame_mode;
            r_frame_start  <= n_frame_start;
            r_frame_hit    <= n_frame_hit;
            r_chan_valid   <= n_chan_valid;
            r_b_valid      <= n_b_valid;
            r_fwd_hit      <= n_fwd_hit;
            r_out_valid    <= n_out_valid;
        end
        r_b          <= n_b;
        r_fwd_sample <= n_fwd_sample;
        r_out        <= n_out;
    end

    lcd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (CHANNELS),
        .AW    (CH_AW)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (b_go && b_store),
        .i_waddr (r_b.addr),
        .i_wdata (r_b.sample),
        .i_re    (o_pop),
        .i_raddr (i_head.addr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[rtl/core/lcd_checker.sv]
// ----------------------------------------------------------------------------
// lcd_checker
// Port-level checks of the detector, bound to the top level.
// ----------------------------------------------------------------------------
module lcd_checker
    import lcd_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input t_in_item                 i_in_item,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input t_out_item                o_out_item,
    input logic                     i_cfg_we,
    input logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input logic [CFG_DATA_BITS-1:0] i_cfg_wdata
);

    logic [EVENT_BITS-1:0] r_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evt <= '0;
        end else if (i_cfg_we && i_cfg_index == CFG_EVENT_ID) begin
            r_evt <= i_cfg_wdata[EVENT_BITS-1:0];
        end
    end

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_item))
        else $error("sample transaction withdrawn or changed before accept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("event transaction dropped before accept");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("stalled event payload changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.event_code == r_evt)
        else $error("event code differs from configured code");

endmodule

bind multichannel_level_crossing_detector_top lcd_checker u_lcd_checker (.*);
